FILE: sv/lr1p_pkg.sv
// Shared types, codes and default sizes for the LR(1) parse engine.
// Used by lr1_shift_reduce_parser_unit; depends on nothing.
package lr1p_pkg;

	localparam int STATES_DEF       = 256;
	localparam int TERMINALS_DEF    = 64;
	localparam int NONTERMINALS_DEF = 64;
	localparam int PRODUCTIONS_DEF  = 256;
	localparam int STACK_DEPTH_DEF  = 64;
	localparam int STEP_LIMIT_DEF   = 32;

	localparam logic [2:0] OP_TOKEN   = 3'd0;
	localparam logic [2:0] OP_WR_ACT  = 3'd1;
	localparam logic [2:0] OP_WR_GOTO = 3'd2;
	localparam logic [2:0] OP_WR_RULE = 3'd3;
	localparam logic [2:0] OP_RESTART = 3'd4;

	localparam logic [1:0] KIND_ERROR  = 2'd0;
	localparam logic [1:0] KIND_SHIFT  = 2'd1;
	localparam logic [1:0] KIND_REDUCE = 2'd2;
	localparam logic [1:0] KIND_ACCEPT = 2'd3;

	localparam logic [1:0] REG_STATE_COUNT = 2'd0;
	localparam logic [1:0] REG_TERM_COUNT  = 2'd1;
	localparam logic [1:0] REG_PROD_COUNT  = 2'd2;
	localparam logic [1:0] REG_END_MARKER  = 2'd3;

	typedef enum logic [3:0] {
		STS_RUNNING    = 4'd0,
		STS_ACCEPT     = 4'd1,
		STS_BAD_STATE  = 4'd2,
		STS_BAD_TOKEN  = 4'd3,
		STS_BAD_SHIFT  = 4'd4,
		STS_BAD_RULE   = 4'd5,
		STS_UNDERFLOW  = 4'd6,
		STS_EMPTY_GOTO = 4'd7,
		STS_ERR_ACTION = 4'd8,
		STS_OVERFLOW   = 4'd9,
		STS_STEP_LIMIT = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		PH_RUN    = 2'd0,
		PH_ACCEPT = 2'd1,
		PH_FAIL   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_LOOK  = 3'd1,
		ST_ACT   = 3'd2,
		ST_RULE  = 3'd3,
		ST_BELOW = 3'd4,
		ST_GOTO  = 3'd5
	} fsm_t;

endpackage

FILE: sv/lr1_shift_reduce_parser_unit.sv
// LR(1) table-driven shift-reduce parse engine with table and stack memories.
// A shift passes through LOOK and ACT, a reduce through LOOK, ACT, RULE, BELOW and GOTO;
// each action waits for the output register. Writes and restarts complete in IDLE.
// Throughput: one item in IDLE per cycle; a token chain runs in the sequencer
// over the action, rule, stack and goto memory reads. Reset is asynchronous
// and restores the initial stack (state 0), counters and register defaults.
module lr1_shift_reduce_parser_unit #(
	parameter int STATES       = lr1p_pkg::STATES_DEF,
	parameter int TERMINALS    = lr1p_pkg::TERMINALS_DEF,
	parameter int NONTERMINALS = lr1p_pkg::NONTERMINALS_DEF,
	parameter int PRODUCTIONS  = lr1p_pkg::PRODUCTIONS_DEF,
	parameter int STACK_DEPTH  = lr1p_pkg::STACK_DEPTH_DEF,
	parameter int STEP_LIMIT   = lr1p_pkg::STEP_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// row, column, entry_kind, target, rule_length, rule_lhs, token (from bit 0)
	input  logic [47:0] s_tdata,
	// operation
	input  logic [2:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// current_state, lookahead, taken_kind, taken_value, status, action_number
	output logic [47:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int AAW  = $clog2(STATES * TERMINALS) > 0 ? $clog2(STATES * TERMINALS) : 1;
	localparam int GAW  = $clog2(STATES * NONTERMINALS) > 0 ?
		$clog2(STATES * NONTERMINALS) : 1;
	localparam int RAW  = $clog2(PRODUCTIONS) > 0 ? $clog2(PRODUCTIONS) : 1;
	localparam int SIW  = $clog2(STACK_DEPTH);
	localparam int SPW  = $clog2(STACK_DEPTH + 1);
	localparam int STW  = $clog2(STEP_LIMIT + 1);

	logic [9:0]        act_mem  [STATES * TERMINALS];
	logic signed [8:0] goto_mem [STATES * NONTERMINALS];
	logic [9:0]        rule_mem [PRODUCTIONS];
	logic [7:0]        stk_mem  [STACK_DEPTH];

	lr1p_pkg::fsm_t   state_q, state_n;
	lr1p_pkg::phase_t phase_q;
	logic [8:0]  sc_q, pc_q;
	logic [6:0]  tc_q;
	logic [5:0]  em_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]  top_q;
	logic [5:0]  la_q;
	logic        eoi_q;
	logic [STW-1:0] steps_q;
	logic [15:0] cnt_q;
	logic [1:0]  kind_q;
	logic [7:0]  val_q;
	logic [5:0]  lhs_q;
	logic [9:0]  act_rd_q, rule_rd_q;
	logic signed [8:0] goto_rd_q;
	logic [7:0]  stk_rd_q;
	logic        idx_zero_q;

	logic [2:0]  op;
	logic [7:0]  row;
	logic [5:0]  col;
	logic [1:0]  in_kind;
	logic [8:0]  in_target;
	logic [3:0]  in_rlen;
	logic [5:0]  in_rlhs;
	logic [5:0]  in_token;
	logic        in_acc, out_free;

	logic        emit, e_last, e_fail, e_accept, e_cnt, push, act_re, rule_re, stk_re, goto_re;
	logic [1:0]  e_kind;
	logic [7:0]  e_val, push_val;
	lr1p_pkg::status_t e_status;
	logic [15:0] cnt_n;
	logic [SPW-1:0] sp_pop;
	logic [7:0]  below;
	logic [1:0]  a_kind;
	logic [7:0]  a_val;
	logic [3:0]  r_len;

	assign op        = s_tuser;
	assign row       = s_tdata[7:0];
	assign col       = s_tdata[13:8];
	assign in_kind   = s_tdata[15:14];
	assign in_target = s_tdata[24:16];
	assign in_rlen   = s_tdata[28:25];
	assign in_rlhs   = s_tdata[34:29];
	assign in_token  = s_tdata[40:35];

	assign s_tready = (state_q == lr1p_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign cnt_n    = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
	assign a_kind   = act_rd_q[9:8];
	assign a_val    = act_rd_q[7:0];
	assign r_len    = rule_rd_q[9:6];
	assign sp_pop   = sp_q - SPW'(r_len);
	assign below    = idx_zero_q ? 8'd0 : stk_rd_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lr1p_pkg::ST_IDLE: begin
				if (in_acc && op == lr1p_pkg::OP_TOKEN && phase_q == lr1p_pkg::PH_RUN)
					state_n = lr1p_pkg::ST_LOOK;
			end
			lr1p_pkg::ST_LOOK: begin
				if (act_re)
					state_n = lr1p_pkg::ST_ACT;
				else if (emit)
					state_n = lr1p_pkg::ST_IDLE;
			end
			lr1p_pkg::ST_ACT: begin
				if (rule_re)
					state_n = lr1p_pkg::ST_RULE;
				else if (emit)
					state_n = (push && eoi_q) ? lr1p_pkg::ST_LOOK : lr1p_pkg::ST_IDLE;
			end
			lr1p_pkg::ST_RULE: begin
				if (stk_re)
					state_n = lr1p_pkg::ST_BELOW;
				else if (emit)
					state_n = lr1p_pkg::ST_IDLE;
			end
			lr1p_pkg::ST_BELOW: begin
				if (goto_re)
					state_n = lr1p_pkg::ST_GOTO;
				else if (emit)
					state_n = lr1p_pkg::ST_IDLE;
			end
			lr1p_pkg::ST_GOTO: begin
				if (emit)
					state_n = push ? lr1p_pkg::ST_LOOK : lr1p_pkg::ST_IDLE;
			end
			default: state_n = lr1p_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0; e_last = 1'b1; e_fail = 1'b0; e_accept = 1'b0; e_cnt = 1'b0;
		push = 1'b0; push_val = a_val;
		act_re = 1'b0; rule_re = 1'b0; stk_re = 1'b0; goto_re = 1'b0;
		e_kind = kind_q; e_val = val_q; e_status = lr1p_pkg::STS_RUNNING;
		unique case (state_q)
			lr1p_pkg::ST_LOOK: begin
				e_kind = lr1p_pkg::KIND_ERROR; e_val = 8'd0;
				if (32'(steps_q) >= STEP_LIMIT) begin
					emit = out_free; e_fail = 1'b1; e_status = lr1p_pkg::STS_STEP_LIMIT;
				end else if ({1'b0, top_q} >= sc_q || 32'(top_q) >= STATES) begin
					emit = out_free; e_fail = 1'b1; e_status = lr1p_pkg::STS_BAD_STATE;
				end else if ({1'b0, la_q} >= tc_q || 32'(la_q) >= TERMINALS) begin
					emit = out_free; e_fail = 1'b1; e_status = lr1p_pkg::STS_BAD_TOKEN;
				end else begin
					act_re = 1'b1;
				end
			end
			lr1p_pkg::ST_ACT: begin
				e_kind = a_kind; e_val = a_val;
				if (out_free) begin
					e_cnt = 1'b1;
					case (a_kind)
						lr1p_pkg::KIND_ERROR: begin
							emit = 1'b1; e_fail = 1'b1; e_status = lr1p_pkg::STS_ERR_ACTION;
						end
						lr1p_pkg::KIND_ACCEPT: begin
							emit = 1'b1; e_accept = 1'b1; e_status = lr1p_pkg::STS_ACCEPT;
						end
						lr1p_pkg::KIND_SHIFT: begin
							emit = 1'b1;
							if ({1'b0, a_val} >= sc_q) begin
								e_fail = 1'b1; e_status = lr1p_pkg::STS_BAD_SHIFT;
							end else if (32'(sp_q) >= STACK_DEPTH) begin
								e_fail = 1'b1; e_status = lr1p_pkg::STS_OVERFLOW;
							end else begin
								push = 1'b1; e_last = !eoi_q;
							end
						end
						default: begin
							if ({1'b0, a_val} >= pc_q || 32'(a_val) >= PRODUCTIONS) begin
								emit = 1'b1; e_fail = 1'b1; e_status = lr1p_pkg::STS_BAD_RULE;
							end else begin
								rule_re = 1'b1;
							end
						end
					endcase
				end
			end
			lr1p_pkg::ST_RULE: begin
				if (SPW'(r_len) >= sp_q) begin
					emit = out_free; e_fail = 1'b1; e_status = lr1p_pkg::STS_UNDERFLOW;
				end else begin
					stk_re = 1'b1;
				end
			end
			lr1p_pkg::ST_BELOW: begin
				if (32'(lhs_q) >= NONTERMINALS || 32'(below) >= STATES) begin
					emit = out_free; e_fail = 1'b1; e_status = lr1p_pkg::STS_EMPTY_GOTO;
				end else begin
					goto_re = 1'b1;
				end
			end
			lr1p_pkg::ST_GOTO: begin
				emit = out_free; push_val = goto_rd_q[7:0];
				if (goto_rd_q < 0) begin
					e_fail = 1'b1; e_status = lr1p_pkg::STS_EMPTY_GOTO;
				end else if (32'(sp_q) >= STACK_DEPTH) begin
					e_fail = 1'b1; e_status = lr1p_pkg::STS_OVERFLOW;
				end else begin
					push = out_free; e_last = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lr1p_pkg::ST_IDLE;
			phase_q <= lr1p_pkg::PH_RUN;
			sc_q <= 9'd256; tc_q <= 7'd64; pc_q <= 9'd256; em_q <= 6'd0;
			sp_q <= SPW'(1); top_q <= 8'd0; cnt_q <= 16'd0; steps_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				unique case (cfg_index)
					lr1p_pkg::REG_STATE_COUNT: sc_q <= cfg_data;
					lr1p_pkg::REG_TERM_COUNT:  tc_q <= cfg_data[6:0];
					lr1p_pkg::REG_PROD_COUNT:  pc_q <= cfg_data;
					lr1p_pkg::REG_END_MARKER:  em_q <= cfg_data[5:0];
				endcase
			end
			if (in_acc && op == lr1p_pkg::OP_RESTART) begin
				phase_q <= lr1p_pkg::PH_RUN; sp_q <= SPW'(1); top_q <= 8'd0; cnt_q <= 16'd0;
			end
			if (in_acc && op == lr1p_pkg::OP_TOKEN)
				steps_q <= '0;
			if (act_re)
				steps_q <= steps_q + STW'(1);
			if (e_cnt)
				cnt_q <= cnt_n;
			if (e_fail && emit)
				phase_q <= lr1p_pkg::PH_FAIL;
			if (e_accept)
				phase_q <= lr1p_pkg::PH_ACCEPT;
			if (stk_re)
				sp_q <= sp_pop;
			if (push) begin
				sp_q <= sp_q + SPW'(1); top_q <= push_val;
			end
			if (emit)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == lr1p_pkg::OP_TOKEN) begin
			la_q <= in_token; eoi_q <= s_tlast;
		end
		if (push && eoi_q && state_q == lr1p_pkg::ST_ACT)
			la_q <= em_q;
		if (rule_re) begin
			kind_q <= a_kind; val_q <= a_val;
		end
		if (stk_re)
			lhs_q <= rule_rd_q[5:0];
		if (emit) begin
			m_tdata <= {4'd0, (e_cnt ? cnt_n : cnt_q), e_status, e_val, e_kind, la_q, top_q};
			m_tlast <= e_last;
		end
	end

	// Table memories: written by load items, read one entry per cycle by the sequencer.
	always_ff @(posedge clk) begin
		if (in_acc && op == lr1p_pkg::OP_WR_ACT && 32'(row) < STATES && 32'(col) < TERMINALS)
			act_mem[AAW'(32'(row) * TERMINALS + 32'(col))] <= {in_kind, in_target[7:0]};
		if (act_re)
			act_rd_q <= act_mem[AAW'(32'(top_q) * TERMINALS + 32'(la_q))];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == lr1p_pkg::OP_WR_GOTO && 32'(row) < STATES &&
				32'(col) < NONTERMINALS)
			goto_mem[GAW'(32'(row) * NONTERMINALS + 32'(col))] <= in_target;
		if (goto_re)
			goto_rd_q <= goto_mem[GAW'(32'(below) * NONTERMINALS + 32'(lhs_q))];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == lr1p_pkg::OP_WR_RULE && 32'(row) < PRODUCTIONS)
			rule_mem[RAW'(row)] <= {in_rlen, in_rlhs};
		if (rule_re)
			rule_rd_q <= rule_mem[RAW'(a_val)];
	end

	// Entry zero always reads as the initial state, so it is never stored.
	always_ff @(posedge clk) begin
		if (push)
			stk_mem[sp_q[SIW-1:0]] <= push_val;
		if (stk_re) begin
			stk_rd_q   <= stk_mem[SIW'(sp_pop - SPW'(1))];
			idx_zero_q <= (sp_pop == SPW'(1));
		end
	end

`ifndef SYNTHESIS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q != '0 && 32'(sp_q) <= STACK_DEPTH)
		else $error("stack pointer out of range");
	a_busy_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lr1p_pkg::ST_IDLE |-> phase_q == lr1p_pkg::PH_RUN)
		else $error("sequencer busy on a stopped parse");
	a_emit_space: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result written over a pending transfer");
`endif

endmodule

FILE: verif/tb_lr1_shift_reduce_parser_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for lr1_shift_reduce_parser_unit: loads parse tables, streams tokens
// and compares every result transfer with an in-bench parse engine. Depends on lr1p_pkg and the RTL.
module tb_lr1_shift_reduce_parser_unit;

	localparam int G_ST = 4;
	localparam int G_TM = 8;
	localparam int G_NT = 4;
	localparam int G_PR = 8;

	localparam logic [2:0] OP_INVALID = 3'd7;

	typedef struct packed {
		logic [7:0]  st;
		logic [5:0]  la;
		logic [1:0]  kind;
		logic [7:0]  val;
		logic [3:0]  status;
		logic [15:0] num;
		logic        last;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	// Parse engine mirror.
	logic [9:0]        act_mem [0:lr1p_pkg::STATES_DEF*lr1p_pkg::TERMINALS_DEF-1];
	logic signed [8:0] goto_mem [0:lr1p_pkg::STATES_DEF*lr1p_pkg::NONTERMINALS_DEF-1];
	logic [9:0]        rule_mem [0:lr1p_pkg::PRODUCTIONS_DEF-1];
	logic [7:0]        stk [0:lr1p_pkg::STACK_DEPTH_DEF-1];
	int                sp;
	lr1p_pkg::phase_t  phase;
	int                act_cnt;
	int                n_states, n_terms, n_prods;
	logic [5:0]        end_mark;

	parse_result_t     pending_results[$];
	int                errors = 0;
	bit                quiet = 1'b0;
	int                rx_hold = 0;

	lr1_shift_reduce_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		if (quiet || $urandom_range(0, 2) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else begin
			rx_hold <= pick_gap();
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending, status", m_tdata[27:24], 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] != want.st) report_mismatch("current_state", m_tdata[7:0], want.st);
				if (m_tdata[13:8] != want.la) report_mismatch("lookahead", m_tdata[13:8], want.la);
				if (m_tdata[15:14] != want.kind)
					report_mismatch("taken_kind", m_tdata[15:14], want.kind);
				if (m_tdata[23:16] != want.val)
					report_mismatch("taken_value", m_tdata[23:16], want.val);
				if (m_tdata[27:24] != want.status)
					report_mismatch("status", m_tdata[27:24], want.status);
				if (m_tdata[43:28] != want.num)
					report_mismatch("action_number", m_tdata[43:28], want.num);
				if (m_tlast != want.last) report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	task automatic restart_engine();
		for (int i = 0; i < lr1p_pkg::STACK_DEPTH_DEF; i++)
			stk[i] = 8'd0;
		sp = 1;
		phase = lr1p_pkg::PH_RUN;
		act_cnt = 0;
	endtask

	task automatic add_result(input logic [7:0] st, input logic [5:0] la, input logic [1:0] kind,
			input logic [7:0] val, input lr1p_pkg::status_t status);
		parse_result_t r;
		r = '{st: st, la: la, kind: kind, val: val, status: status, num: act_cnt[15:0], last: 1'b0};
		pending_results.push_back(r);
		if (status != lr1p_pkg::STS_RUNNING && status != lr1p_pkg::STS_ACCEPT)
			phase = lr1p_pkg::PH_FAIL;
		if (status == lr1p_pkg::STS_ACCEPT)
			phase = lr1p_pkg::PH_ACCEPT;
	endtask

	task automatic parse_token(input logic [5:0] tok, input logic eoi);
		int steps;
		int base;
		logic [5:0] la;
		logic [7:0] st, val, below;
		logic [1:0] kind;
		logic [3:0] len;
		logic [5:0] lhs;
		logic signed [8:0] g;
		steps = 0;
		base = pending_results.size();
		la = tok;
		if (phase != lr1p_pkg::PH_RUN)
			return;
		forever begin
			st = stk[(sp - 1) % lr1p_pkg::STACK_DEPTH_DEF];
			if (steps >= lr1p_pkg::STEP_LIMIT_DEF) begin
				add_result(st, la, lr1p_pkg::KIND_ERROR, 8'd0, lr1p_pkg::STS_STEP_LIMIT);
				break;
			end
			steps++;
			if (st >= n_states) begin
				add_result(st, la, lr1p_pkg::KIND_ERROR, 8'd0, lr1p_pkg::STS_BAD_STATE);
				break;
			end
			if (la >= n_terms) begin
				add_result(st, la, lr1p_pkg::KIND_ERROR, 8'd0, lr1p_pkg::STS_BAD_TOKEN);
				break;
			end
			kind = act_mem[st * lr1p_pkg::TERMINALS_DEF + la][9:8];
			val = act_mem[st * lr1p_pkg::TERMINALS_DEF + la][7:0];
			if (act_cnt < 65535)
				act_cnt++;
			if (kind == lr1p_pkg::KIND_ERROR) begin
				add_result(st, la, kind, val, lr1p_pkg::STS_ERR_ACTION);
				break;
			end
			if (kind == lr1p_pkg::KIND_ACCEPT) begin
				add_result(st, la, kind, val, lr1p_pkg::STS_ACCEPT);
				break;
			end
			if (kind == lr1p_pkg::KIND_SHIFT) begin
				if (val >= n_states) begin
					add_result(st, la, kind, val, lr1p_pkg::STS_BAD_SHIFT);
					break;
				end
				if (sp >= lr1p_pkg::STACK_DEPTH_DEF) begin
					add_result(st, la, kind, val, lr1p_pkg::STS_OVERFLOW);
					break;
				end
				stk[sp] = val;
				sp++;
				add_result(st, la, kind, val, lr1p_pkg::STS_RUNNING);
				if (!eoi)
					break;
				la = end_mark;
				continue;
			end
			if (val >= n_prods) begin
				add_result(st, la, kind, val, lr1p_pkg::STS_BAD_RULE);
				break;
			end
			len = rule_mem[val][9:6];
			lhs = rule_mem[val][5:0];
			if (len >= sp) begin
				add_result(st, la, kind, val, lr1p_pkg::STS_UNDERFLOW);
				break;
			end
			sp -= len;
			below = stk[(sp - 1) % lr1p_pkg::STACK_DEPTH_DEF];
			g = goto_mem[below * lr1p_pkg::NONTERMINALS_DEF + lhs];
			if (g < 0) begin
				add_result(st, la, kind, val, lr1p_pkg::STS_EMPTY_GOTO);
				break;
			end
			if (sp >= lr1p_pkg::STACK_DEPTH_DEF) begin
				add_result(st, la, kind, val, lr1p_pkg::STS_OVERFLOW);
				break;
			end
			stk[sp] = g[7:0];
			sp++;
			add_result(st, la, kind, val, lr1p_pkg::STS_RUNNING);
		end
		if (pending_results.size() > base)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endtask

	task automatic send_item(input logic [2:0] op, input logic [7:0] row, input logic [5:0] col,
			input logic [1:0] kind, input logic [8:0] target, input logic [3:0] rlen,
			input logic [5:0] rlhs, input logic [5:0] tok, input logic eoi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, tok, rlhs, rlen, target, kind, col, row};
		s_tuser <= op;
		s_tlast <= eoi;
		do @(posedge clk); while (!s_tready);
		case (op)
			lr1p_pkg::OP_WR_ACT: act_mem[row * lr1p_pkg::TERMINALS_DEF + col] = {kind, target[7:0]};
			lr1p_pkg::OP_WR_GOTO: goto_mem[row * lr1p_pkg::NONTERMINALS_DEF + col] = target;
			lr1p_pkg::OP_WR_RULE: rule_mem[row] = {rlen, rlhs};
			lr1p_pkg::OP_RESTART: restart_engine();
			lr1p_pkg::OP_TOKEN: parse_token(tok, eoi);
			default: ;
		endcase
	endtask

	task automatic wr_action(input int row, input int col, input logic [1:0] kind, input int tgt);
		send_item(lr1p_pkg::OP_WR_ACT, 8'(row), 6'(col), kind, 9'(tgt), 4'($urandom),
			6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	task automatic wr_goto(input int row, input int col, input int tgt);
		send_item(lr1p_pkg::OP_WR_GOTO, 8'(row), 6'(col), 2'($urandom), 9'(tgt), 4'($urandom),
			6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	task automatic wr_rule(input int row, input int len, input int lhs);
		send_item(lr1p_pkg::OP_WR_RULE, 8'(row), 6'($urandom), 2'($urandom), 9'($urandom),
			4'(len), 6'(lhs), 6'($urandom), 1'($urandom));
	endtask

	task automatic restart_parse();
		send_item(lr1p_pkg::OP_RESTART, 8'($urandom), 6'($urandom), 2'($urandom), 9'($urandom),
			4'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	task automatic token(input int tok, input logic eoi);
		send_item(lr1p_pkg::OP_TOKEN, 8'($urandom), 6'($urandom), 2'($urandom), 9'($urandom),
			4'($urandom), 6'($urandom), 6'(tok), eoi);
	endtask

	// Waits for all pending results and for the engine to settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 9'(value);
		@(posedge clk);
	endtask

	task automatic set_limits(input int states, input int terms, input int prods, input int em);
		cfg_write(lr1p_pkg::REG_STATE_COUNT, states);
		cfg_write(lr1p_pkg::REG_TERM_COUNT, terms);
		cfg_write(lr1p_pkg::REG_PROD_COUNT, prods);
		cfg_write(lr1p_pkg::REG_END_MARKER, em);
		cfg_we <= 1'b0;
		n_states = states;
		n_terms = terms;
		n_prods = prods;
		end_mark = 6'(em);
	endtask

	task automatic test_table_extremes();
		wr_action(0, 63, lr1p_pkg::KIND_SHIFT, 255);
		wr_action(255, 63, lr1p_pkg::KIND_ACCEPT, -1);
		token(63, 1'b0);
		token(63, 1'b0);
		token(63, 1'b0);
		send_item(OP_INVALID, 8'($urandom), 6'($urandom), 2'($urandom), 9'($urandom),
			4'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
		restart_parse();
		wr_action(0, 1, lr1p_pkg::KIND_ERROR, 0);
		token(1, 1'b0);
	endtask

	task automatic test_reduce_paths();
		wr_rule(0, 1, 2);
		wr_goto(0, 2, 1);
		wr_action(0, 0, lr1p_pkg::KIND_SHIFT, 2);
		wr_action(2, 0, lr1p_pkg::KIND_REDUCE, 0);
		wr_action(1, 0, lr1p_pkg::KIND_ACCEPT, 0);
		restart_parse();
		token(0, 1'b1);
		wr_goto(0, 2, -1);
		restart_parse();
		token(0, 1'b1);
		wr_rule(0, 15, 63);
		restart_parse();
		token(0, 1'b1);
		// A zero-length rule whose goto returns to the same state loops until the step limit.
		wr_rule(0, 0, 2);
		wr_goto(2, 2, 2);
		restart_parse();
		token(0, 1'b1);
	endtask

	task automatic test_stack_overflow();
		wr_action(0, 1, lr1p_pkg::KIND_SHIFT, 3);
		wr_action(3, 1, lr1p_pkg::KIND_SHIFT, 3);
		restart_parse();
		repeat (lr1p_pkg::STACK_DEPTH_DEF + 1)
			token(1, 1'b0);
	endtask

	task automatic load_random_grammar();
		int k;
		for (int s = 0; s < G_ST; s++)
			for (int t = 0; t < G_TM; t++) begin
				k = $urandom_range(0, 19);
				if (k < 8)
					wr_action(s, t, lr1p_pkg::KIND_SHIFT, $urandom_range(0, G_ST - 1));
				else if (k < 16)
					wr_action(s, t, lr1p_pkg::KIND_REDUCE, $urandom_range(0, G_PR - 1));
				else if (k < 18)
					wr_action(s, t, lr1p_pkg::KIND_ACCEPT, $urandom_range(0, 255));
				else
					wr_action(s, t, lr1p_pkg::KIND_ERROR, $urandom_range(0, 255));
			end
		for (int s = 0; s < G_ST; s++)
			for (int n = 0; n < G_NT; n++)
				wr_goto(s, n, ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, G_ST - 1));
		for (int p = 0; p < G_PR; p++)
			wr_rule(p, ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3),
				$urandom_range(0, G_NT - 1));
	endtask

	task automatic test_random_parses(input int items);
		int k;
		restart_parse();
		for (int i = 0; i < items; i++) begin
			k = $urandom_range(0, 19);
			if (k < 15)
				token($urandom_range(0, G_TM - 1), $urandom_range(0, 3) == 0);
			else if (k < 18)
				restart_parse();
			else
				wr_action($urandom_range(0, G_ST - 1), $urandom_range(0, G_TM - 1),
					2'($urandom_range(1, 3)), $urandom_range(0, G_ST - 1));
		end
		drain();
	endtask

	initial begin
		restart_engine();
		n_states = 256;
		n_terms = 64;
		n_prods = 256;
		end_mark = 6'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_extremes();
		test_reduce_paths();
		drain();
		quiet = 1'b1;
		test_stack_overflow();
		drain();
		quiet = 1'b0;
		load_random_grammar();
		drain();
		test_random_parses(10);
		set_limits(256, 64, 256, 0);
		test_random_parses(8);
		quiet = 1'b1;
		set_limits(1, 64, 256, 0);
		test_random_parses(6);
		quiet = 1'b0;
		set_limits(5, 6, 4, 7);
		test_random_parses(8);
		set_limits(8, 8, 8, 3);
		test_random_parses(10);
		quiet = 1'b1;
		set_limits(256, 1, 1, 0);
		test_random_parses(6);
		quiet = 1'b0;
		set_limits(256, 63, 256, 63);
		test_random_parses(6);
		set_limits(256, 64, 256, 5);
		test_random_parses(10);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
sv/lr1p_pkg.sv
sv/lr1_shift_reduce_parser_unit.sv
verif/tb_lr1_shift_reduce_parser_unit.sv
